// ===== rtl/rbtq_pkg.sv =====
`timescale 1ns / 1ps

package rbtq_pkg;

  localparam int THREAD_COUNT_DEF = 64;

  localparam int CMD_W    = 3;
  localparam int TID_W    = 6;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_MARK_READY = 3'd0,
    CMD_DEQUEUE    = 3'd1,
    CMD_BLOCK      = 3'd2,
    CMD_REREADY    = 3'd3,
    CMD_FORGET     = 3'd4
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  // Micro-operations that the controller asks of the datapath.
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_MARK,
    DP_DEQ_READ,
    DP_DEQ_POP,
    DP_BLOCK,
    DP_REREADY,
    DP_IGNORE,
    DP_EMPTY,
    DP_WALK_START,
    DP_WALK_READ,
    DP_WALK_STEP,
    DP_FORGET_READ,
    DP_FORGET_END,
    DP_FORGET_FIX
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             mark_ok;
    logic             block_ok;
    logic             ready_nonempty;
    logic             in_any_list;
    logic             cur_is_tid;
    logic             cur_is_last;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== rtl/ready_blocked_thread_queue_top.sv =====
`timescale 1ns / 1ps
// Ready/blocked thread queue. Each request on the s_ channel carries a command
// (mark ready, dequeue, block, re-ready all blocked, forget) and a thread id;
// each request gives exactly one result on the m_ channel with a status, the
// popped thread for a dequeue and the emptiness of both lists afterwards.
// Both lists are FIFOs linked through one shared next-pointer memory of
// THREAD_COUNT entries with a registered read port.
// Requests are handled one at a time. Mark ready, block, re-ready and any
// ignored request load their result from the execute state; a dequeue
// first reads the new head from the link memory. Forget walks its list from
// the head, with one link memory read per thread ahead of the target, and
// then splices the target out. The next request is taken the cycle after
// the result is loaded.
// The result sits in an output register; while it waits, the next request is
// still accepted, but it completes only once that result has been taken.
// After reset both lists are empty and no result is pending. The link memory
// is not cleared: an entry's value is only used after it has been written.
module ready_blocked_thread_queue_top import rbtq_pkg::*; #(
  parameter int THREAD_COUNT = THREAD_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // command[2:0], req_thread[8:3], is_terminated[9], zero above
  input  logic [DATA_W-1:0] s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // status[1:0], dequeued_thread[7:2], dequeued_valid[8], ready_empty[9],
  // blocked_nonempty[10], zero above
  output logic [DATA_W-1:0] m_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [STATUS_W-1:0] status;
  logic [TID_W-1:0]    dequeued_thread;
  logic                dequeued_valid;
  logic                ready_empty;
  logic                blocked_nonempty;

  rbtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbtq_dp #(
    .THREAD_COUNT (THREAD_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .command          (s_tdata[2:0]),
    .req_thread       (s_tdata[8:3]),
    .is_terminated    (s_tdata[9]),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .status           (status),
    .dequeued_thread  (dequeued_thread),
    .dequeued_valid   (dequeued_valid),
    .ready_empty      (ready_empty),
    .blocked_nonempty (blocked_nonempty)
  );

  assign m_tdata = {5'd0, blocked_nonempty, ready_empty, dequeued_valid, dequeued_thread,
                    status};

endmodule

// ===== rtl/rbtq_ctrl.sv =====
`timescale 1ns / 1ps

module rbtq_ctrl import rbtq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ_POP,
    S_WALK,
    S_WALK_WAIT,
    S_FIX
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = DP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.cmd)
          CMD_MARK_READY: begin
            if (stat.out_free) begin
              cmd.op     = stat.mark_ok ? DP_MARK : DP_IGNORE;
              state_next = S_IDLE;
            end
          end
          CMD_DEQUEUE: begin
            if (stat.ready_nonempty) begin
              cmd.op     = DP_DEQ_READ;
              state_next = S_DEQ_POP;
            end else if (stat.out_free) begin
              cmd.op     = DP_EMPTY;
              state_next = S_IDLE;
            end
          end
          CMD_BLOCK: begin
            if (stat.out_free) begin
              cmd.op     = stat.block_ok ? DP_BLOCK : DP_IGNORE;
              state_next = S_IDLE;
            end
          end
          CMD_REREADY: begin
            if (stat.out_free) begin
              cmd.op     = DP_REREADY;
              state_next = S_IDLE;
            end
          end
          CMD_FORGET: begin
            if (stat.in_any_list) begin
              cmd.op     = DP_WALK_START;
              state_next = S_WALK;
            end else if (stat.out_free) begin
              cmd.op     = DP_IGNORE;
              state_next = S_IDLE;
            end
          end
          default: begin
            if (stat.out_free) begin
              cmd.op     = DP_IGNORE;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_DEQ_POP: begin
        if (stat.out_free) begin
          cmd.op     = DP_DEQ_POP;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        // A thread in the middle or at the head of a longer list needs its own
        // link read before it can be spliced out.
        if (stat.cur_is_tid && !stat.cur_is_last) begin
          cmd.op     = DP_FORGET_READ;
          state_next = S_FIX;
        end else if (stat.cur_is_tid || stat.cur_is_last) begin
          if (stat.out_free) begin
            cmd.op     = DP_FORGET_END;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op     = DP_WALK_READ;
          state_next = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        cmd.op     = DP_WALK_STEP;
        state_next = S_WALK;
      end
      S_FIX: begin
        if (stat.out_free) begin
          cmd.op     = DP_FORGET_FIX;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/rbtq_dp.sv =====
`timescale 1ns / 1ps

module rbtq_dp import rbtq_pkg::*; #(
  parameter int THREAD_COUNT = THREAD_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [CMD_W-1:0]    command,
  input  logic [TID_W-1:0]    req_thread,
  input  logic                is_terminated,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [TID_W-1:0]    dequeued_thread,
  output logic                dequeued_valid,
  output logic                ready_empty,
  output logic                blocked_nonempty
);

  localparam int IW = $clog2(THREAD_COUNT);
  localparam int CW = $clog2(THREAD_COUNT + 1);

  // Request held for the duration of its execution.
  logic [CMD_W-1:0] cmd_r;
  logic [TID_W-1:0] tid_r;
  logic             term_r;

  logic [IW-1:0] ready_first, ready_first_next;
  logic [IW-1:0] ready_last, ready_last_next;
  logic [IW-1:0] blocked_first, blocked_first_next;
  logic [IW-1:0] blocked_last, blocked_last_next;
  logic [THREAD_COUNT-1:0] queued, queued_next;
  logic [THREAD_COUNT-1:0] blocked, blocked_next;
  logic [CW-1:0] ready_count, ready_count_next;
  logic [CW-1:0] blocked_count, blocked_count_next;

  // List walk for forget.
  logic          walk_sel, walk_sel_next;
  logic [IW-1:0] cur, cur_next;
  logic [IW-1:0] prev, prev_next;
  logic          have_prev, have_prev_next;

  // Shared next-pointer store.
  logic [IW-1:0] link_mem [THREAD_COUNT];
  logic [IW-1:0] rdata;
  logic          rd_en;
  logic [IW-1:0] raddr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_wdata;

  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [TID_W-1:0]    emit_thread;
  logic                emit_valid;

  logic          tid_ok;
  logic [IW-1:0] tid_ix;
  logic          q_hit;
  logic          b_hit;
  logic [IW-1:0] list_last;

  assign tid_ok    = 32'(tid_r) < 32'(THREAD_COUNT);
  assign tid_ix    = IW'(tid_r);
  assign q_hit     = tid_ok && queued[tid_ix];
  assign b_hit     = tid_ok && blocked[tid_ix];
  assign list_last = walk_sel ? blocked_last : ready_last;

  always_comb begin
    stat.cmd            = cmd_r;
    stat.mark_ok        = tid_ok && !term_r && !q_hit && !b_hit;
    stat.block_ok       = tid_ok && !q_hit && !b_hit;
    stat.ready_nonempty = (ready_count != '0);
    stat.in_any_list    = q_hit || b_hit;
    stat.cur_is_tid     = (cur == tid_ix);
    stat.cur_is_last    = (cur == list_last);
    stat.out_free       = !out_valid || out_ready;
  end

  always_comb begin
    ready_first_next   = ready_first;
    ready_last_next    = ready_last;
    blocked_first_next = blocked_first;
    blocked_last_next  = blocked_last;
    queued_next        = queued;
    blocked_next       = blocked;
    ready_count_next   = ready_count;
    blocked_count_next = blocked_count;
    walk_sel_next      = walk_sel;
    cur_next           = cur;
    prev_next          = prev;
    have_prev_next     = have_prev;
    rd_en              = 1'b0;
    raddr              = cur;
    mem_we             = 1'b0;
    mem_waddr          = ready_last;
    mem_wdata          = tid_ix;
    emit               = 1'b0;
    emit_status        = ST_DONE;
    emit_thread        = '0;
    emit_valid         = 1'b0;

    case (cmd.op) inside
      DP_MARK: begin
        if (ready_count != '0) begin
          mem_we    = 1'b1;
          mem_waddr = ready_last;
          mem_wdata = tid_ix;
        end else begin
          ready_first_next = tid_ix;
        end
        ready_last_next     = tid_ix;
        queued_next[tid_ix] = 1'b1;
        ready_count_next    = ready_count + CW'(1);
        emit                = 1'b1;
      end
      DP_DEQ_READ: begin
        rd_en = 1'b1;
        raddr = ready_first;
      end
      DP_DEQ_POP: begin
        if (ready_first != ready_last) begin
          ready_first_next = rdata;
        end
        queued_next[ready_first] = 1'b0;
        ready_count_next         = ready_count - CW'(1);
        emit                     = 1'b1;
        emit_thread              = TID_W'(ready_first);
        emit_valid               = 1'b1;
      end
      DP_BLOCK: begin
        if (blocked_count != '0) begin
          mem_we    = 1'b1;
          mem_waddr = blocked_last;
          mem_wdata = tid_ix;
        end else begin
          blocked_first_next = tid_ix;
        end
        blocked_last_next    = tid_ix;
        blocked_next[tid_ix] = 1'b1;
        blocked_count_next   = blocked_count + CW'(1);
        emit                 = 1'b1;
      end
      DP_REREADY: begin
        if (blocked_count != '0) begin
          if (ready_count != '0) begin
            mem_we    = 1'b1;
            mem_waddr = ready_last;
            mem_wdata = blocked_first;
          end else begin
            ready_first_next = blocked_first;
          end
          ready_last_next    = blocked_last;
          queued_next        = queued | blocked;
          blocked_next       = '0;
          ready_count_next   = ready_count + blocked_count;
          blocked_count_next = '0;
        end
        emit = 1'b1;
      end
      DP_IGNORE: begin
        emit        = 1'b1;
        emit_status = ST_IGNORED;
      end
      DP_EMPTY: begin
        emit        = 1'b1;
        emit_status = ST_EMPTY;
      end
      DP_WALK_START: begin
        walk_sel_next  = !q_hit;
        cur_next       = q_hit ? ready_first : blocked_first;
        have_prev_next = 1'b0;
      end
      DP_WALK_READ, DP_FORGET_READ: begin
        rd_en = 1'b1;
        raddr = cur;
      end
      DP_WALK_STEP: begin
        prev_next      = cur;
        cur_next       = rdata;
        have_prev_next = 1'b1;
      end
      DP_FORGET_END, DP_FORGET_FIX: begin
        if (cmd.op == DP_FORGET_END) begin
          // The tail goes: its predecessor becomes the new tail.
          if ((cur == tid_ix) && have_prev) begin
            if (walk_sel) begin
              blocked_last_next = prev;
            end else begin
              ready_last_next = prev;
            end
          end
        end else if (!have_prev) begin
          if (walk_sel) begin
            blocked_first_next = rdata;
          end else begin
            ready_first_next = rdata;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = prev;
          mem_wdata = rdata;
        end
        if (walk_sel) begin
          blocked_next[tid_ix] = 1'b0;
          blocked_count_next   = blocked_count - CW'(1);
        end else begin
          queued_next[tid_ix] = 1'b0;
          ready_count_next    = ready_count - CW'(1);
        end
        emit = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= link_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_first   <= '0;
      ready_last    <= '0;
      blocked_first <= '0;
      blocked_last  <= '0;
      queued        <= '0;
      blocked       <= '0;
      ready_count   <= '0;
      blocked_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      ready_first   <= ready_first_next;
      ready_last    <= ready_last_next;
      blocked_first <= blocked_first_next;
      blocked_last  <= blocked_last_next;
      queued        <= queued_next;
      blocked       <= blocked_next;
      ready_count   <= ready_count_next;
      blocked_count <= blocked_count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      cmd_r  <= command;
      tid_r  <= req_thread;
      term_r <= is_terminated;
    end
    walk_sel  <= walk_sel_next;
    cur       <= cur_next;
    prev      <= prev_next;
    have_prev <= have_prev_next;
    if (emit) begin
      status           <= emit_status;
      dequeued_thread  <= emit_thread;
      dequeued_valid   <= emit_valid;
      ready_empty      <= (ready_count_next == '0);
      blocked_nonempty <= (blocked_count_next != '0);
    end
  end

endmodule

// ===== rtl/rbtq_checker.sv =====
`timescale 1ns / 1ps

module rbtq_assertions import rbtq_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic [DATA_W-1:0] s_tdata,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata
);

  // A result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Requests are executed one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another executes");

  // A popped thread only comes with a done status, and otherwise reads as zero.
  a_deq_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8] ? (m_tdata[1:0] == ST_DONE)
                             : (m_tdata[7:2] == '0)))
    else $error("dequeued thread fields inconsistent");

  // An empty report means the ready list really is empty, and nothing popped.
  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == ST_EMPTY) |-> m_tdata[9] && !m_tdata[8])
    else $error("empty status without empty ready list");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ST_DONE) || (m_tdata[1:0] == ST_IGNORED) ||
                 (m_tdata[1:0] == ST_EMPTY))
    else $error("undefined status code");

endmodule

bind ready_blocked_thread_queue_top rbtq_assertions u_rbtq_assertions (.*);
